// ===== rtl/kcc_pkg.sv =====
// shared types and constants for the keyed caesar cipher
package kcc_pkg;

  localparam int unsigned ALPHA_SIZE = 26;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned OUT_W      = 7;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned KLEN_W     = 5;
  localparam int unsigned KWORD_W    = 40;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_AMOUNT  = 3'd0,
    CFG_DECRYPT_MODE  = 3'd1,
    CFG_KEYWORD_LEN   = 3'd2,
    CFG_KEYWORD_LOW   = 3'd3,
    CFG_KEYWORD_HIGH  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    BUILD_IDLE,
    BUILD_SWEEP
  } build_state_e;

  // keyword settings seen by the alphabet builder
  typedef struct packed {
    logic [KLEN_W-1:0]  len;
    logic [KWORD_W-1:0] low;
    logic [KWORD_W-1:0] high;
  } kcc_key_t;

  // one write into both tables
  typedef struct packed {
    logic                en;
    logic [LETTER_W-1:0] pos;
    logic [LETTER_W-1:0] letter;
  } kcc_wr_t;

endpackage

// ===== rtl/kcc_alpha_build.sv =====
// sequencer that sweeps the keyword and the plain alphabet to fill the tables
module kcc_alpha_build #(
  parameter int unsigned MAX_KEY_LETTERS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  kcc_pkg::kcc_key_t key_i,
  output kcc_pkg::kcc_wr_t wr_o,
  output logic             busy_o
);
  import kcc_pkg::*;

  localparam int unsigned NumSlots = MAX_KEY_LETTERS + ALPHA_SIZE;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  build_state_e state_q, state_d;
  logic [SlotW-1:0]      slot_q, slot_d;
  logic [LETTER_W-1:0]   count_q, count_d;
  logic [ALPHA_SIZE-1:0] used_q, used_d;

  logic [KLEN_W-1:0]   len_eff;
  logic [3:0]          kidx;
  logic [KWORD_W-1:0]  kword;
  logic [LETTER_W-1:0] letter;
  logic                cand_ok;
  logic                take;

  always_comb begin
    if (key_i.len > KLEN_W'(MAX_KEY_LETTERS)) len_eff = KLEN_W'(MAX_KEY_LETTERS);
    else len_eff = key_i.len;
  end

  assign kidx  = slot_q[3:0];
  assign kword = kidx[3] ? key_i.high : key_i.low;

  always_comb begin
    if (slot_q < SlotW'(MAX_KEY_LETTERS)) begin
      letter  = kword[kidx[2:0]*LETTER_W +: LETTER_W];
      cand_ok = {{(SlotW > KLEN_W ? SlotW-KLEN_W : 0){1'b0}}, len_eff} > slot_q;
    end else begin
      letter  = LETTER_W'(slot_q - SlotW'(MAX_KEY_LETTERS));
      cand_ok = 1'b1;
    end
  end

  assign take = (state_q == BUILD_SWEEP) && cand_ok
                && (letter < LETTER_W'(ALPHA_SIZE))
                && !used_q[letter]
                && (count_q < LETTER_W'(ALPHA_SIZE));

  assign wr_o.en     = take;
  assign wr_o.pos    = count_q;
  assign wr_o.letter = letter;
  assign busy_o      = (state_q == BUILD_SWEEP);

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    count_d = count_q;
    used_d  = used_q;
    if (start_i) begin
      state_d = BUILD_SWEEP;
      slot_d  = '0;
      count_d = '0;
      used_d  = '0;
    end else begin
      unique case (state_q)
        BUILD_IDLE: begin
        end
        BUILD_SWEEP: begin
          if (take) begin
            used_d[letter] = 1'b1;
            count_d        = count_q + LETTER_W'(1);
          end
          slot_d = slot_q + SlotW'(1);
          if (slot_q == SlotW'(NumSlots - 1)) state_d = BUILD_IDLE;
        end
        default: state_d = BUILD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BUILD_SWEEP;
      slot_q  <= '0;
      count_q <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      count_q <= count_d;
      used_q  <= used_d;
    end
  end

endmodule

// ===== rtl/kcc_lookup.sv =====
// character pipeline around the position and alphabet memories
module kcc_lookup (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kcc_pkg::kcc_wr_t                 wr_i,
  input  logic                             hold_i,
  input  logic [kcc_pkg::SHIFT_W-1:0]      shift_i,
  input  logic                             decrypt_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kcc_pkg::CHAR_W-1:0]       in_char_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kcc_pkg::OUT_W-1:0]        out_char_o
);
  import kcc_pkg::*;

  logic [LETTER_W-1:0] pos_mem   [ALPHA_SIZE];
  logic [LETTER_W-1:0] alpha_mem [ALPHA_SIZE];

  logic [LETTER_W-1:0] pos_q;
  logic [LETTER_W-1:0] alpha_q;
  logic                v1_q, v2_q, vo_q;
  logic [OUT_W-1:0]    out_q;

  logic                en0, en1, en2, accept;
  logic [CHAR_W-1:0]   ch;
  logic                is_letter;
  logic [LETTER_W-1:0] rd_addr;
  logic [SHIFT_W-1:0]  shift_mod;
  logic [5:0]          sum;
  logic [LETTER_W-1:0] target;

  assign en2        = !vo_q || out_ready_i;
  assign en1        = !v2_q || en2;
  assign en0        = !v1_q || en1;
  assign in_ready_o = en0 && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  // fold lower case in encrypt mode
  always_comb begin
    ch = in_char_i;
    if (!decrypt_i && in_char_i >= ASCII_LOWER_A && in_char_i <= ASCII_LOWER_Z) begin
      ch = in_char_i - CASE_OFFSET;
    end
  end

  assign is_letter = (ch >= ASCII_UPPER_A) && (ch <= ASCII_UPPER_Z);
  assign rd_addr   = is_letter ? LETTER_W'(ch - ASCII_UPPER_A) : '0;

  assign shift_mod = (shift_i >= SHIFT_W'(ALPHA_SIZE)) ? shift_i - SHIFT_W'(ALPHA_SIZE)
                                                       : shift_i;

  always_comb begin
    if (decrypt_i) sum = {1'b0, pos_q} + 6'(ALPHA_SIZE) - {1'b0, shift_mod};
    else sum = {1'b0, pos_q} + {1'b0, shift_mod};
    if (sum >= 6'(ALPHA_SIZE)) target = LETTER_W'(sum - 6'(ALPHA_SIZE));
    else target = sum[LETTER_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pos_mem[wr_i.letter] <= wr_i.pos;
      alpha_mem[wr_i.pos]  <= wr_i.letter;
    end
    if (en0) pos_q <= pos_mem[rd_addr];
    if (en1) alpha_q <= alpha_mem[target];
    if (en2) out_q <= OUT_W'(ASCII_UPPER_A) + OUT_W'(alpha_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en0) v1_q <= accept && is_letter;
      if (en1) v2_q <= v1_q;
      if (en2) vo_q <= v2_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_char_o  = out_q;

endmodule

// ===== rtl/keyed_caesar_cipher.sv =====
// top level of the keyed caesar cipher: config registers, builder and lookup
// an input transfer passes the position, alphabet and output registers in order
// throughput: one character per cycle while the output is not stalled, set by the
// single read port of each memory; reset and every write to a known register
// index start an alphabet build that fills both memories; no input is taken until
// it finishes. reset values: shift 1, encrypt, empty keyword (plain alphabet)
module keyed_caesar_cipher #(
  parameter int unsigned MAX_KEY_LETTERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // in_char[7:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // out_char[6:0], zero[7]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kcc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [kcc_pkg::KWORD_W-1:0]       cfg_data_i
);
  import kcc_pkg::*;

  logic [SHIFT_W-1:0] shift_q;
  logic               decrypt_q;
  logic [KLEN_W-1:0]  klen_q;
  logic [KWORD_W-1:0] klow_q, khigh_q;

  logic             cfg_write, known_idx, build_busy;
  kcc_key_t         key;
  kcc_wr_t          wr;
  logic [OUT_W-1:0] out_char;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    unique case (cfg_index_i)
      CFG_SHIFT_AMOUNT, CFG_DECRYPT_MODE, CFG_KEYWORD_LEN,
      CFG_KEYWORD_LOW, CFG_KEYWORD_HIGH: known_idx = 1'b1;
      default:                           known_idx = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= SHIFT_W'(1);
      decrypt_q <= 1'b0;
      klen_q    <= '0;
      klow_q    <= '0;
      khigh_q   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_SHIFT_AMOUNT: shift_q   <= cfg_data_i[SHIFT_W-1:0];
        CFG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];
        CFG_KEYWORD_LEN:  klen_q    <= cfg_data_i[KLEN_W-1:0];
        CFG_KEYWORD_LOW:  klow_q    <= cfg_data_i;
        CFG_KEYWORD_HIGH: khigh_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign key.len  = klen_q;
  assign key.low  = klow_q;
  assign key.high = khigh_q;

  kcc_alpha_build #(
    .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
  ) u_build (
    .clk_i,
    .rst_ni,
    .start_i (cfg_write && known_idx),
    .key_i   (key),
    .wr_o    (wr),
    .busy_o  (build_busy)
  );

  kcc_lookup u_lookup (
    .clk_i,
    .rst_ni,
    .wr_i        (wr),
    .hold_i      (build_busy),
    .shift_i     (shift_q),
    .decrypt_i   (decrypt_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
